// ===== src/ofcf_pkg.sv =====
package ofcf_pkg;

  // Default capacities.
  localparam int unsigned DefMaxWidth   = 64;
  localparam int unsigned DefMaxHeight  = 64;
  localparam int unsigned DefMaxPoints  = 1024;
  localparam int unsigned DefMaxReports = 64;

  // Register reset values.
  localparam int unsigned RstDim       = 64;
  localparam int unsigned RstMinPoints = 10;

  // Field widths.
  localparam int unsigned CellW  = 8;
  localparam int unsigned StartW = 16;
  localparam int unsigned MinPW  = 13;
  localparam int unsigned DimInW = 7;
  localparam int unsigned CountW = 11;
  localparam int unsigned SumW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinPoints  = 2'd2;

  // Input item kinds.
  localparam logic ActLoad = 1'b0;
  localparam logic ActRun  = 1'b1;

  // Cell codes that matter for frontier detection.
  localparam logic [CellW-1:0] CellUnknown = 8'hFF;
  localparam logic [CellW-1:0] CellFree    = 8'h00;

  // Sequencer states.
  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_SCAN     = 19'h00002,
    ST_CL_START = 19'h00004,
    ST_CL_PT    = 19'h00008,
    ST_CL_NB    = 19'h00010,
    ST_CL_CHK   = 19'h00020,
    ST_CL_RL    = 19'h00040,
    ST_CL_MA    = 19'h00080,
    ST_CL_MB    = 19'h00100,
    ST_CL_MC    = 19'h00200,
    ST_CL_MD    = 19'h00400,
    ST_CL_FIN   = 19'h00800,
    ST_CL_ADD   = 19'h01000,
    ST_RP_CA    = 19'h02000,
    ST_RP_CB    = 19'h04000,
    ST_RP_SEL   = 19'h08000,
    ST_RP_EA    = 19'h10000,
    ST_RP_EB    = 19'h20000,
    ST_RP_NULL  = 19'h40000
  } state_e;

  // True when one cell is unknown and the other free.
  function automatic logic pair_edge(logic [CellW-1:0] a, logic [CellW-1:0] b);
    return ((a == CellUnknown) && (b == CellFree)) ||
           ((b == CellUnknown) && (a == CellFree));
  endfunction

endpackage

// ===== src/ofcf_ram.sv =====
module ofcf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/occupancy_frontier_cluster_finder.sv =====
// Occupancy grid frontier cluster finder.
// Input channel (s_axis): tuser selects the item kind. A load item writes
// tdata's cell value into the next grid cell in row-major order. A run item
// scans the grid if its start index is inside it, clusters frontier cells and
// reports the clusters. Output channel (m_axis): one transaction per reported
// cluster, tlast on the final one; a run with nothing to report gives one
// transaction with the valid flag clear. Configuration writes go through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must make them only while the block
// is idle, as the block itself does not enforce it. The scan makes five reads
// per grid cell, since the grid memory has one read port; then each frontier
// point is compared with every earlier point, with a relabel sweep over the
// earlier points on every merge, and the labels are walked once for counting
// and once more for reporting. s_axis_tready is high only between runs.
// Reset returns registers to their defaults and the load pointer to zero;
// grid contents are undefined until loaded. A stalled receiver holds the
// result in the output register and the sequencer waits for it.
module occupancy_frontier_cluster_finder
  import ofcf_pkg::*;
#(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned MaxPoints  = DefMaxPoints,
  parameter int unsigned MaxReports = DefMaxReports
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // cell_value[7:0], start_index[23:8]
  input  logic                s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // point_count[10:0], col_sum[26:11], row_sum[42:27], zero[47:43]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser,  // cluster_valid[0], truncated[1]
  output logic                m_axis_tlast
);

  localparam int unsigned GridCells = MaxWidth * MaxHeight;
  localparam int unsigned GA  = $clog2(GridCells);
  localparam int unsigned NW  = $clog2(GridCells + 1);
  localparam int unsigned XW  = (NW + 1 > StartW) ? NW + 1 : StartW;
  localparam int unsigned DW  = $clog2(MaxWidth + 1);
  localparam int unsigned HW  = $clog2(MaxHeight + 1);
  localparam int unsigned CW  = $clog2(MaxWidth);
  localparam int unsigned RW  = $clog2(MaxHeight);
  localparam int unsigned KW  = (DW > HW ? DW : HW) > DimInW ? (DW > HW ? DW : HW) : DimInW;
  localparam int unsigned PAW = $clog2(MaxPoints);
  localparam int unsigned PCW = $clog2(MaxPoints + 1);
  localparam int unsigned LCW = $clog2(MaxPoints + 2);
  localparam int unsigned SZW = PCW;
  localparam int unsigned CLW = SZW + 2 * SumW;
  localparam int unsigned MW  = SZW > MinPW ? SZW : MinPW;
  localparam int unsigned RPW = $clog2(MaxReports + 1);
  localparam int unsigned QW  = LCW > RPW ? LCW : RPW;
  localparam int unsigned RstW = (RstDim > MaxWidth) ? MaxWidth : RstDim;
  localparam int unsigned RstH = (RstDim > MaxHeight) ? MaxHeight : RstDim;

  // Configuration registers.
  logic [DW-1:0]    wid_q;
  logic [HW-1:0]    hgt_q;
  logic [MinPW-1:0] minp_q;
  logic [KW-1:0]    cfg_dim;
  logic [DW-1:0]    wid_clamp;
  logic [HW-1:0]    hgt_clamp;

  // Sequencer state.
  state_e          state_q, state_d;
  logic [GA-1:0]   ldp_q, ldp_d;
  logic [NW-1:0]   n_q, n_d;
  logic [GA-1:0]   c_q, c_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [2:0]      step_q, step_d;
  logic [CellW-1:0] v_q, v_d;
  logic            acc_q, acc_d;
  logic            trunc_q, trunc_d;
  logic [PCW-1:0]  np_q, np_d;
  logic [PCW-1:0]  id_q, id_d;
  logic [PCW-1:0]  id2_q, id2_d;
  logic [PCW-1:0]  i_q, i_d;
  logic [PCW-1:0]  ip_q, ip_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   pc_q, pc_d;
  logic [RW-1:0]   pr_q, pr_d;
  logic [PCW-1:0]  lab_q, lab_d;
  logic [PCW-1:0]  oth_q, oth_d;
  logic [CLW-1:0]  suma_q, suma_d;
  logic [LCW-1:0]  labels_q, labels_d;
  logic [LCW-1:0]  ri_q, ri_d;
  logic [LCW-1:0]  qual_q, qual_d;
  logic [RPW-1:0]  tot_q, tot_d;
  logic [RPW-1:0]  em_q, em_d;

  // Output register.
  logic                mv_q;
  logic [OutDataW-1:0] md_q;
  logic [1:0]          mu_q;
  logic                ml_q;
  logic                out_load;
  logic [OutDataW-1:0] out_data;
  logic [1:0]          out_user;
  logic                out_last;
  logic                out_free;

  // Memory ports.
  logic                 g_we;
  logic [GA-1:0]        g_waddr, g_raddr;
  logic [CellW-1:0]     g_rdata;
  logic                 p_we;
  logic [PAW-1:0]       p_waddr, p_raddr;
  logic [RW+CW-1:0]     p_wdata, p_rdata;
  logic                 l_we;
  logic [PAW-1:0]       l_waddr, l_raddr;
  logic [PCW-1:0]       l_wdata, l_rdata;
  logic                 k_we;
  logic [PCW-1:0]       k_waddr, k_raddr;
  logic [CLW-1:0]       k_wdata, k_rdata;

  // Helpers.
  logic                 in_acc;
  logic [NW-1:0]        n_comb;
  logic [StartW-1:0]    start;
  logic                 start_ok;
  logic [XW-1:0]        c_x, w_x, n_x;
  logic                 nb_ok, hit;
  logic [CW-1:0]        q_col, dc;
  logic [RW-1:0]        q_row, dr;
  logic                 adj;
  logic [CLW-1:0]       inc_word;
  logic [CLW-1:0]       rep_word;
  logic [SZW-1:0]       rep_size;
  logic                 rep_qual;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free = !mv_q || m_axis_tready;

  // Grid size for the run that is about to start.
  assign n_comb = NW'(wid_q * hgt_q);
  assign start  = s_axis_tdata[CellW +: StartW];
  assign start_ok = !start[StartW-1] && (XW'(start) < XW'(n_comb));

  // Configuration write with dimension clamping.
  assign cfg_dim   = KW'(cfg_data_i[DimInW-1:0]);
  assign wid_clamp = (cfg_dim == '0) ? DW'(1) :
                     (cfg_dim > KW'(MaxWidth)) ? DW'(MaxWidth) : DW'(cfg_dim);
  assign hgt_clamp = (cfg_dim == '0) ? HW'(1) :
                     (cfg_dim > KW'(MaxHeight)) ? HW'(MaxHeight) : HW'(cfg_dim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q  <= DW'(RstW);
      hgt_q  <= HW'(RstH);
      minp_q <= MinPW'(RstMinPoints);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridWidth:  wid_q  <= wid_clamp;
        CfgGridHeight: hgt_q  <= hgt_clamp;
        CfgMinPoints:  minp_q <= cfg_data_i[MinPW-1:0];
        default: ;
      endcase
    end
  end

  // Neighbor validity for the current scan step.
  assign c_x = XW'(c_q);
  assign w_x = XW'(wid_q);
  assign n_x = XW'(n_q);
  always_comb begin
    case (step_q)
      3'd2:    nb_ok = (c_q != '0);
      3'd3:    nb_ok = (c_x + XW'(1)) < n_x;
      3'd4:    nb_ok = c_x >= w_x;
      3'd5:    nb_ok = (c_x + w_x) < n_x;
      default: nb_ok = 1'b0;
    endcase
  end
  assign hit = nb_ok && pair_edge(v_q, g_rdata);

  // Manhattan adjacency of the current point and an earlier one.
  assign q_col = p_rdata[CW-1:0];
  assign q_row = p_rdata[RW+CW-1:CW];
  assign dc = (pc_q > q_col) ? pc_q - q_col : q_col - pc_q;
  assign dr = (pr_q > q_row) ? pr_q - q_row : q_row - pr_q;
  assign adj = ((dc == '0) && (dr <= RW'(1))) || ((dr == '0) && (dc <= CW'(1)));

  assign inc_word = {SZW'(1), SumW'(pc_q), SumW'(pr_q)};

  // Label zero is never written and always reads as empty, sums included.
  assign rep_word = (ri_q == '0) ? '0 : k_rdata;
  assign rep_size = rep_word[CLW-1 -: SZW];
  assign rep_qual = MW'(rep_size) >= MW'(minp_q);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    ldp_d    = ldp_q;
    n_d      = n_q;
    c_d      = c_q;
    col_d    = col_q;
    row_d    = row_q;
    step_d   = step_q;
    v_d      = v_q;
    acc_d    = acc_q;
    trunc_d  = trunc_q;
    np_d     = np_q;
    id_d     = id_q;
    id2_d    = id2_q;
    i_d      = i_q;
    ip_d     = ip_q;
    pend_d   = pend_q;
    pc_d     = pc_q;
    pr_d     = pr_q;
    lab_d    = lab_q;
    oth_d    = oth_q;
    suma_d   = suma_q;
    labels_d = labels_q;
    ri_d     = ri_q;
    qual_d   = qual_q;
    tot_d    = tot_q;
    em_d     = em_q;

    g_we    = 1'b0;
    g_waddr = ldp_q;
    g_raddr = c_q;
    p_we    = 1'b0;
    p_waddr = np_q[PAW-1:0];
    p_wdata = {row_q, col_q};
    p_raddr = id_q[PAW-1:0];
    l_we    = 1'b0;
    l_waddr = id_q[PAW-1:0];
    l_wdata = lab_q;
    l_raddr = id2_q[PAW-1:0];
    k_we    = 1'b0;
    k_waddr = lab_q;
    k_wdata = '0;
    k_raddr = ri_q[PCW-1:0];

    out_load = 1'b0;
    out_data = '0;
    out_user = '0;
    out_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ActLoad) begin
            g_we  = 1'b1;
            ldp_d = (ldp_q == GA'(GridCells - 1)) ? '0 : ldp_q + GA'(1);
          end else begin
            ldp_d    = '0;
            n_d      = n_comb;
            np_d     = '0;
            trunc_d  = 1'b0;
            labels_d = LCW'(1);
            id_d     = '0;
            c_d      = '0;
            col_d    = '0;
            row_d    = '0;
            step_d   = '0;
            acc_d    = 1'b0;
            state_d  = start_ok ? ST_SCAN : ST_CL_START;
          end
        end
      end

      // Five reads per cell: the cell itself, then its four neighbors.
      ST_SCAN: begin
        case (step_q)
          3'd1:    g_raddr = c_q - GA'(1);
          3'd2:    g_raddr = c_q + GA'(1);
          3'd3:    g_raddr = c_q - GA'(wid_q);
          3'd4:    g_raddr = c_q + GA'(wid_q);
          default: g_raddr = c_q;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd1) begin
          v_d = g_rdata;
        end else if (step_q > 3'd1 && step_q < 3'd5) begin
          acc_d = acc_q | hit;
        end else if (step_q == 3'd5) begin
          step_d = '0;
          acc_d  = 1'b0;
          if (acc_q | hit) begin
            if (np_q < PCW'(MaxPoints)) begin
              p_we = 1'b1;
              np_d = np_q + PCW'(1);
            end else begin
              trunc_d = 1'b1;
            end
          end
          if ((c_x + XW'(1)) == n_x) begin
            state_d = ST_CL_START;
          end else begin
            c_d = c_q + GA'(1);
            if ((DW'(col_q) + DW'(1)) == wid_q) begin
              col_d = '0;
              row_d = row_q + RW'(1);
            end else begin
              col_d = col_q + CW'(1);
            end
          end
        end
      end

      ST_CL_START: begin
        p_raddr = id_q[PAW-1:0];
        if (id_q == np_q) begin
          ri_d    = '0;
          qual_d  = '0;
          state_d = ST_RP_CA;
        end else begin
          state_d = ST_CL_PT;
        end
      end

      ST_CL_PT: begin
        pc_d    = p_rdata[CW-1:0];
        pr_d    = p_rdata[RW+CW-1:CW];
        lab_d   = '0;
        id2_d   = '0;
        state_d = ST_CL_NB;
      end

      // Walk the earlier points in order.
      ST_CL_NB: begin
        p_raddr = id2_q[PAW-1:0];
        l_raddr = id2_q[PAW-1:0];
        state_d = (id2_q == id_q) ? ST_CL_FIN : ST_CL_CHK;
      end

      ST_CL_CHK: begin
        if (!adj) begin
          id2_d   = id2_q + PCW'(1);
          state_d = ST_CL_NB;
        end else if (lab_q != '0 && lab_q != l_rdata) begin
          oth_d   = l_rdata;
          i_d     = '0;
          pend_d  = 1'b0;
          state_d = ST_CL_RL;
        end else begin
          lab_d   = l_rdata;
          id2_d   = id2_q + PCW'(1);
          state_d = ST_CL_NB;
        end
      end

      // Relabel sweep: read one label per cycle; one that holds the absorbed label is rewritten in the next cycle.
      ST_CL_RL: begin
        l_raddr = i_q[PAW-1:0];
        l_waddr = ip_q[PAW-1:0];
        l_wdata = oth_q;
        if (pend_q && l_rdata == lab_q) begin
          l_we = 1'b1;
        end
        if (i_q != id_q) begin
          pend_d = 1'b1;
          ip_d   = i_q;
          i_d    = i_q + PCW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_CL_MA;
          end
        end
      end

      // Move the absorbed label's totals into the surviving one.
      ST_CL_MA: begin
        k_raddr = lab_q;
        state_d = ST_CL_MB;
      end

      ST_CL_MB: begin
        suma_d  = k_rdata;
        k_raddr = oth_q;
        state_d = ST_CL_MC;
      end

      ST_CL_MC: begin
        k_we    = 1'b1;
        k_waddr = oth_q;
        k_wdata = {k_rdata[CLW-1 -: SZW] + suma_q[CLW-1 -: SZW],
                   k_rdata[2*SumW-1:SumW] + suma_q[2*SumW-1:SumW],
                   k_rdata[SumW-1:0] + suma_q[SumW-1:0]};
        state_d = ST_CL_MD;
      end

      ST_CL_MD: begin
        k_we    = 1'b1;
        k_waddr = lab_q;
        k_wdata = '0;
        lab_d   = oth_q;
        id2_d   = id2_q + PCW'(1);
        state_d = ST_CL_NB;
      end

      // Open a new label or add the point to the one found.
      ST_CL_FIN: begin
        k_raddr = lab_q;
        if (lab_q == '0) begin
          k_we     = 1'b1;
          k_waddr  = labels_q[PCW-1:0];
          k_wdata  = inc_word;
          l_we     = 1'b1;
          l_wdata  = labels_q[PCW-1:0];
          labels_d = labels_q + LCW'(1);
          id_d     = id_q + PCW'(1);
          state_d  = ST_CL_START;
        end else begin
          state_d = ST_CL_ADD;
        end
      end

      ST_CL_ADD: begin
        k_we    = 1'b1;
        k_waddr = lab_q;
        k_wdata = {k_rdata[CLW-1 -: SZW] + SZW'(1),
                   k_rdata[2*SumW-1:SumW] + SumW'(pc_q),
                   k_rdata[SumW-1:0] + SumW'(pr_q)};
        l_we    = 1'b1;
        l_wdata = lab_q;
        id_d    = id_q + PCW'(1);
        state_d = ST_CL_START;
      end

      // First pass counts the qualifying labels.
      ST_RP_CA: begin
        state_d = ST_RP_CB;
      end

      ST_RP_CB: begin
        if (rep_qual) begin
          qual_d = qual_q + LCW'(1);
        end
        if ((ri_q + LCW'(1)) == labels_q) begin
          state_d = ST_RP_SEL;
        end else begin
          ri_d    = ri_q + LCW'(1);
          state_d = ST_RP_CA;
        end
      end

      ST_RP_SEL: begin
        ri_d = '0;
        em_d = '0;
        if (qual_q == '0) begin
          state_d = ST_RP_NULL;
        end else begin
          if (QW'(qual_q) > QW'(MaxReports)) begin
            tot_d   = RPW'(MaxReports);
            trunc_d = 1'b1;
          end else begin
            tot_d = RPW'(qual_q);
          end
          state_d = ST_RP_EA;
        end
      end

      // Second pass sends the qualifying labels, up to MaxReports of them.
      ST_RP_EA: begin
        state_d = ST_RP_EB;
      end

      ST_RP_EB: begin
        if (!rep_qual) begin
          ri_d    = ri_q + LCW'(1);
          state_d = ST_RP_EA;
        end else if (out_free) begin
          out_load = 1'b1;
          out_data = OutDataW'({rep_word[SumW-1:0], rep_word[2*SumW-1:SumW],
                                CountW'(rep_size)});
          out_user = {trunc_q, 1'b1};
          out_last = (em_q + RPW'(1)) == tot_q;
          em_d     = em_q + RPW'(1);
          if (out_last) begin
            state_d = ST_IDLE;
          end else begin
            ri_d    = ri_q + LCW'(1);
            state_d = ST_RP_EA;
          end
        end
      end

      ST_RP_NULL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_user = {trunc_q, 1'b0};
          out_last = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ldp_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ldp_q   <= ldp_d;
      if (out_load) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    c_q      <= c_d;
    col_q    <= col_d;
    row_q    <= row_d;
    step_q   <= step_d;
    v_q      <= v_d;
    acc_q    <= acc_d;
    trunc_q  <= trunc_d;
    np_q     <= np_d;
    id_q     <= id_d;
    id2_q    <= id2_d;
    i_q      <= i_d;
    ip_q     <= ip_d;
    pend_q   <= pend_d;
    pc_q     <= pc_d;
    pr_q     <= pr_d;
    lab_q    <= lab_d;
    oth_q    <= oth_d;
    suma_q   <= suma_d;
    labels_q <= labels_d;
    ri_q     <= ri_d;
    qual_q   <= qual_d;
    tot_q    <= tot_d;
    em_q     <= em_d;
    if (out_load) begin
      md_q <= out_data;
      mu_q <= out_user;
      ml_q <= out_last;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;
  assign m_axis_tlast  = ml_q;

  // Grid cells.
  ofcf_ram #(.Width(CellW), .Depth(GridCells)) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (s_axis_tdata[CellW-1:0]),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // Frontier points as row and column.
  ofcf_ram #(.Width(RW + CW), .Depth(MaxPoints)) u_points (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Label of each frontier point.
  ofcf_ram #(.Width(PCW), .Depth(MaxPoints)) u_labels (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Size and coordinate sums of each label.
  ofcf_ram #(.Width(CLW), .Depth(MaxPoints + 1)) u_clusters (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

endmodule

// ===== src/ofcf_checker.sv =====
module ofcf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A run occupies the block right after it is taken.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("block ready right after a run was taken");

  // A load never produces a result.
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after a load transaction");

  // Mid-run results mean the block is still busy.
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while a run still has results to send");

endmodule

bind occupancy_frontier_cluster_finder ofcf_checker u_ofcf_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  import ofcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GridCells = DefMaxWidth * DefMaxHeight;
  localparam int unsigned CycleLimit = 8_000_000;

  typedef struct packed {
    logic              cluster_valid;
    logic [CountW-1:0] point_count;
    logic [SumW-1:0]   col_sum;
    logic [SumW-1:0]   row_sum;
    logic              last;
    logic              truncated;
  } cluster_rec_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // cell_value[7:0], start_index[23:8]
  logic                s_axis_tuser;   // action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // point_count, col_sum, row_sum, zero pad
  logic [1:0]          m_axis_tuser;   // cluster_valid, truncated
  logic                m_axis_tlast;

  occupancy_frontier_cluster_finder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Shadow of the block's state and configuration.
  logic [CellW-1:0] grid_img [GridCells];
  bit               cell_loaded [GridCells];
  int unsigned      load_ptr;
  int unsigned      cols, rows, min_size;
  int unsigned      fpts [DefMaxPoints];
  int unsigned      flab [DefMaxPoints];
  int unsigned      lsize [DefMaxPoints+1];
  int unsigned      lcol [DefMaxPoints+1];
  int unsigned      lrow [DefMaxPoints+1];

  cluster_rec_t pending_clusters [$];
  int unsigned  error_count;
  bit           idle_en;
  int unsigned  rx_hold;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit unknown_free(logic [CellW-1:0] a, logic [CellW-1:0] b);
    return (a == CellUnknown && b == CellFree) || (b == CellUnknown && a == CellFree);
  endfunction

  function automatic bit frontier_at(int unsigned c, int unsigned n);
    logic [CellW-1:0] v;
    v = grid_img[c];
    if (c >= 1 && unknown_free(v, grid_img[c-1])) return 1'b1;
    if (c + 1 < n && unknown_free(v, grid_img[c+1])) return 1'b1;
    if (c >= cols && unknown_free(v, grid_img[c-cols])) return 1'b1;
    if (c + cols < n && unknown_free(v, grid_img[c+cols])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned dist1(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned clamp_dim(logic [CfgDataW-1:0] v, int unsigned maxv);
    int unsigned d;
    d = v[6:0];
    if (d == 0) d = 1;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  function automatic bit grid_ready(int unsigned n);
    for (int unsigned c = 0; c < n; c++) if (!cell_loaded[c]) return 1'b0;
    return 1'b1;
  endfunction

  // Scan, cluster and report exactly as the block does for one run item.
  task automatic predict_clusters(logic [StartW-1:0] start);
    int unsigned  n, np, labels, reports, p, pc, pr, q, lab, other;
    bit           trunc;
    cluster_rec_t run_recs [$];
    cluster_rec_t rec;
    n = cols * rows;
    np = 0;
    labels = 1;
    trunc = 1'b0;
    if (start < 16'h8000 && start < n) begin
      for (int unsigned c = 0; c < n; c++) begin
        if (!frontier_at(c, n)) continue;
        if (np < DefMaxPoints) begin
          fpts[np] = c;
          np++;
        end else begin
          trunc = 1'b1;
        end
      end
    end
    for (int unsigned i = 0; i <= DefMaxPoints; i++) begin
      lsize[i] = 0;
      lcol[i] = 0;
      lrow[i] = 0;
    end
    for (int unsigned id = 0; id < np; id++) begin
      p = fpts[id];
      pc = p % cols;
      pr = p / cols;
      lab = 0;
      for (int unsigned j = 0; j < id; j++) begin
        q = fpts[j];
        other = flab[j];
        if (dist1(pc, q % cols) + dist1(pr, q / cols) > 1) continue;
        if (lab != 0 && lab != other) begin
          // Fold the current label into the neighbor's label.
          for (int unsigned k = 0; k < id; k++) if (flab[k] == lab) flab[k] = other;
          lsize[other] += lsize[lab];
          lcol[other] += lcol[lab];
          lrow[other] += lrow[lab];
          lsize[lab] = 0;
          lcol[lab] = 0;
          lrow[lab] = 0;
        end
        lab = other;
      end
      if (lab == 0) begin
        lab = labels;
        labels++;
      end
      flab[id] = lab;
      lsize[lab] += 1;
      lcol[lab] += pc;
      lrow[lab] += pr;
    end
    reports = 0;
    for (int unsigned i = 0; i < labels; i++) begin
      if (lsize[i] < min_size) continue;
      if (reports >= DefMaxReports) begin
        trunc = 1'b1;
        continue;
      end
      rec = '0;
      rec.cluster_valid = 1'b1;
      rec.point_count = lsize[i][CountW-1:0];
      rec.col_sum = lcol[i][SumW-1:0];
      rec.row_sum = lrow[i][SumW-1:0];
      run_recs = {run_recs, rec};
      reports++;
    end
    if (reports == 0) begin
      rec = '0;
      run_recs = {run_recs, rec};
    end
    foreach (run_recs[i]) begin
      run_recs[i].last = (i == run_recs.size() - 1);
      run_recs[i].truncated = trunc;
      pending_clusters = {pending_clusters, run_recs[i]};
    end
    load_ptr = 0;
  endtask

  // Offer one item and wait until the block takes it.
  task automatic send_item(logic act, logic [CellW-1:0] cval, logic [StartW-1:0] start);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {start, cval};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ActLoad) begin
      grid_img[load_ptr] = cval;
      cell_loaded[load_ptr] = 1'b1;
      load_ptr = (load_ptr + 1) % GridCells;
    end else begin
      predict_clusters(start);
    end
  endtask

  // Stop offering and wait for every outstanding cluster report.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_clusters.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgGridWidth: begin
        cols = clamp_dim(data, DefMaxWidth);
      end
      CfgGridHeight: begin
        rows = clamp_dim(data, DefMaxHeight);
      end
      default: begin
        min_size = data;
      end
    endcase
  endtask

  task automatic load_cell(logic [CellW-1:0] cval);
    send_item(ActLoad, cval, StartW'($urandom));
  endtask

  task automatic run_at(logic [StartW-1:0] start);
    send_item(ActRun, CellW'($urandom), start);
  endtask

  // Default 64x64 shape with no grid loaded: only out-of-grid starts are legal.
  task automatic test_empty_runs();
    run_at(16'h8000);
    run_at(16'h7FFF);
    run_at(16'hFFFF);
    write_reg(CfgMinPoints, 13'd0);
    run_at(16'd4096);
    write_reg(CfgMinPoints, 13'h1FFF);
    run_at(16'h8000);
  endtask

  // A tiny grid with every cell kind, in-grid and just-outside starts.
  task automatic test_small_grid();
    write_reg(CfgGridWidth, 13'h1F80);
    write_reg(CfgGridWidth, 13'd3);
    write_reg(CfgGridHeight, 13'd2);
    write_reg(CfgMinPoints, 13'd1);
    load_cell(CellUnknown);
    load_cell(CellFree);
    load_cell(8'd100);
    load_cell(8'h80);
    load_cell(8'h7F);
    load_cell(CellFree);
    run_at(16'd0);
    run_at(16'd6);
    run_at(16'd5);
    write_reg(CfgMinPoints, 13'd0);
    run_at(16'd2);
  endtask

  // Receiver holds off for a long stretch while runs keep coming.
  task automatic test_output_stall();
    write_reg(CfgGridWidth, 13'd3);
    write_reg(CfgGridHeight, 13'd3);
    write_reg(CfgMinPoints, 13'd1);
    rx_hold = 600;
    for (int unsigned c = 0; c < 9; c++) load_cell((c % 4 == 0) ? CellUnknown : CellFree);
    for (int i = 0; i < 6; i++) run_at(16'd4);
    wait_drained();
  endtask

  function automatic logic [CellW-1:0] random_cell();
    case ($urandom_range(0, 7))
      0, 1, 2: return CellUnknown;
      3, 4, 5: return CellFree;
      6:       return 8'd100;
      default: return CellW'($urandom);
    endcase
  endfunction

  // Random grids of small shapes, with some noise runs and stray loads.
  task automatic test_random();
    int unsigned n;
    for (int seq = 0; seq < 10; seq++) begin
      if (seq == 7) idle_en = 1'b0;
      write_reg(CfgGridWidth, CfgDataW'($urandom_range(0, 5)) | (CfgDataW'($urandom) & 13'h1F80));
      write_reg(CfgGridHeight, CfgDataW'($urandom_range(1, 4)));
      write_reg(CfgMinPoints, CfgDataW'($urandom_range(0, 3)));
      n = cols * rows;
      for (int unsigned c = 0; c < n; c++) load_cell(random_cell());
      if ($urandom_range(0, 3) == 0) load_cell(CellW'($urandom));
      run_at(StartW'($urandom_range(0, n - 1)));
      if ($urandom_range(0, 2) == 0) begin
        if (grid_ready(n) && $urandom_range(0, 1) == 0) run_at(StartW'($urandom_range(0, n - 1)));
        else run_at(StartW'($urandom_range(n, 32'hFFFF)));
      end
    end
  endtask

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted transaction against the oldest expected report.
  always @(posedge clk_i) begin
    cluster_rec_t exp_rec;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_clusters.size() == 0) begin
        $error("unexpected result transaction: tdata=%h", m_axis_tdata);
        error_count++;
      end else begin
        exp_rec = pending_clusters.pop_front();
        if (m_axis_tuser[0] !== exp_rec.cluster_valid) begin
          $error("cluster_valid: expected %0d, got %0d", exp_rec.cluster_valid, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[10:0] !== exp_rec.point_count) begin
          $error("point_count: expected %0d, got %0d", exp_rec.point_count, m_axis_tdata[10:0]);
          error_count++;
        end
        if (m_axis_tdata[26:11] !== exp_rec.col_sum) begin
          $error("col_sum: expected %0d, got %0d", exp_rec.col_sum, m_axis_tdata[26:11]);
          error_count++;
        end
        if (m_axis_tdata[42:27] !== exp_rec.row_sum) begin
          $error("row_sum: expected %0d, got %0d", exp_rec.row_sum, m_axis_tdata[42:27]);
          error_count++;
        end
        if (m_axis_tlast !== exp_rec.last) begin
          $error("last: expected %0d, got %0d", exp_rec.last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser[1] !== exp_rec.truncated) begin
          $error("truncated: expected %0d, got %0d", exp_rec.truncated, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGridWidth;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ActLoad;
    error_count = 0;
    idle_en = 1'b1;
    rx_hold = 0;
    load_ptr = 0;
    cols = RstDim;
    rows = RstDim;
    min_size = RstMinPoints;
    foreach (cell_loaded[i]) cell_loaded[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_runs();
    test_small_grid();
    test_output_stall();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
